// ===== hw/rtl/cpu_exu_pkg.sv =====
package cpu_exu_pkg;

  localparam int unsigned ActionWidth = 6;
  localparam int unsigned DataWidth   = 8;

  localparam logic [DataWidth-1:0] StackReset = 8'hFF;

  typedef enum logic [ActionWidth-1:0] {
    ACT_ADC = 6'd0,  ACT_SBC = 6'd1,  ACT_AND = 6'd2,  ACT_ORA = 6'd3,
    ACT_EOR = 6'd4,  ACT_CMP = 6'd5,  ACT_CPX = 6'd6,  ACT_CPY = 6'd7,
    ACT_BIT = 6'd8,  ACT_LDA = 6'd9,  ACT_LDX = 6'd10, ACT_LDY = 6'd11,
    ACT_ASL = 6'd12, ACT_LSR = 6'd13, ACT_ROL = 6'd14, ACT_ROR = 6'd15,
    ACT_INC = 6'd16, ACT_DEC = 6'd17, ACT_INX = 6'd18, ACT_INY = 6'd19,
    ACT_DEX = 6'd20, ACT_DEY = 6'd21, ACT_TAX = 6'd22, ACT_TAY = 6'd23,
    ACT_TSX = 6'd24, ACT_TXA = 6'd25, ACT_TXS = 6'd26, ACT_TYA = 6'd27,
    ACT_CLC = 6'd28, ACT_SEC = 6'd29, ACT_CLD = 6'd30, ACT_SED = 6'd31,
    ACT_CLI = 6'd32, ACT_SEI = 6'd33, ACT_CLV = 6'd34, ACT_STA = 6'd35,
    ACT_STX = 6'd36, ACT_STY = 6'd37, ACT_SLO = 6'd38, ACT_RLA = 6'd39,
    ACT_SRE = 6'd40, ACT_RRA = 6'd41, ACT_DCP = 6'd42, ACT_ISC = 6'd43,
    ACT_ALR = 6'd44, ACT_ANC = 6'd45, ACT_SAX = 6'd46, ACT_NOP = 6'd47
  } action_e;

  typedef enum logic [1:0] {
    SH_ASL = 2'd0,
    SH_LSR = 2'd1,
    SH_ROL = 2'd2,
    SH_ROR = 2'd3
  } shift_e;

  typedef struct packed {
    logic n;
    logic v;
    logic d;
    logic i;
    logic z;
    logic c;
  } flags_t;

endpackage

// ===== hw/rtl/cpu_exu_if.sv =====
interface cpu_exu_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [cpu_exu_pkg::ActionWidth-1:0]   action;
  logic [cpu_exu_pkg::DataWidth-1:0]     operand;
  logic                                  on_accumulator;

  modport source (output valid, output action, output operand, output on_accumulator,
                  input ready);
  modport sink   (input valid, input action, input operand, input on_accumulator,
                  output ready);
endinterface

interface cpu_exu_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [cpu_exu_pkg::DataWidth-1:0]     store_value;
  logic                                  store_valid;
  logic [cpu_exu_pkg::DataWidth-1:0]     acc_value;
  logic [cpu_exu_pkg::DataWidth-1:0]     x_value;
  logic [cpu_exu_pkg::DataWidth-1:0]     y_value;
  logic [cpu_exu_pkg::DataWidth-1:0]     stack_value;
  logic [cpu_exu_pkg::DataWidth-1:0]     status_byte;

  modport source (output valid, output store_value, output store_valid,
                  output acc_value, output x_value, output y_value,
                  output stack_value, output status_byte, input ready);
  modport sink   (input valid, input store_value, input store_valid,
                  input acc_value, input x_value, input y_value,
                  input stack_value, input status_byte, output ready);
endinterface

// ===== hw/rtl/cpu6502_execute_unit.sv =====
// Data-operation execute unit of a 6502-style core.
// in_i carries one operation per beat: action code, operand byte fetched by
// the addressing stage, and the accumulator-target bit for shifts/rotates.
// out_o returns one beat per operation: the write-back byte with its strobe,
// and A, X, Y, S and the packed status byte after the operation.
// An accepted beat lands in an input register; once the result register is
// free or being taken, it is executed against the register file and the
// result register is loaded, and the result beat stays valid there until
// the receiver takes it.
// Throughput is one operation per cycle while the receiver takes each result:
// the execute logic is an 8-bit combinational path from the input register
// into the register file, so each operation sees the state left by the one before it.
// When the receiver stalls, the result holds and the input register still
// takes one more beat; in_i.ready then drops until the result is taken.
// Reset clears A, X, Y and all flags, sets S to 0xFF; status reads 0x20.
// Arithmetic is always binary; the decimal flag is only stored.
module cpu6502_execute_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  cpu_exu_in_if.sink    in_i,
  cpu_exu_out_if.source out_o
);

  localparam int unsigned DW = cpu_exu_pkg::DataWidth;

  // input register
  logic                                 in_vld_q;
  logic [cpu_exu_pkg::ActionWidth-1:0]  act_q;
  logic [DW-1:0]                        opd_q;
  logic                                 on_acc_q;

  // result register and register file
  logic          out_vld_q;
  logic [DW-1:0] store_q, store_d;
  logic          store_vld_q, store_vld_d;
  logic [DW-1:0] a_q, a_d, x_q, x_d, y_q, y_d, s_q, s_d;
  cpu_exu_pkg::flags_t f_q, f_d;

  logic advance;

  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  // returns {carry_out, result}
  function automatic logic [DW:0] shift_f(cpu_exu_pkg::shift_e kind, logic [DW-1:0] v,
                                          logic cin);
    logic [DW:0] r;
    unique case (kind)
      cpu_exu_pkg::SH_ASL: r = {v[DW-1], v[DW-2:0], 1'b0};
      cpu_exu_pkg::SH_LSR: r = {v[0], 1'b0, v[DW-1:1]};
      cpu_exu_pkg::SH_ROL: r = {v[DW-1], v[DW-2:0], cin};
      cpu_exu_pkg::SH_ROR: r = {v[0], cin, v[DW-1:1]};
      default:             r = {1'b0, v};
    endcase
    return r;
  endfunction

  // returns {overflow, carry_out, sum}
  function automatic logic [DW+1:0] add_f(logic [DW-1:0] a, logic [DW-1:0] m, logic cin);
    logic [DW:0]   sum;
    logic [DW-1:0] r;
    logic          ovf;
    sum = {1'b0, a} + {1'b0, m} + {{DW{1'b0}}, cin};
    r   = sum[DW-1:0];
    ovf = ~(a[DW-1] ^ m[DW-1]) & (a[DW-1] ^ r[DW-1]);
    return {ovf, sum[DW], r};
  endfunction

  always_comb begin
    logic [DW:0]   sh;
    logic [DW+1:0] ad;
    logic [DW:0]   cmp;
    logic [DW-1:0] res;
    logic [DW-1:0] mem;

    a_d = a_q;
    x_d = x_q;
    y_d = y_q;
    s_d = s_q;
    f_d = f_q;
    store_d     = '0;
    store_vld_d = 1'b0;
    sh  = '0;
    ad  = '0;
    cmp = '0;
    res = '0;
    mem = '0;

    unique case (cpu_exu_pkg::action_e'(act_q))
      cpu_exu_pkg::ACT_ADC, cpu_exu_pkg::ACT_SBC: begin
        mem = (act_q == cpu_exu_pkg::ACT_SBC) ? ~opd_q : opd_q;
        ad  = add_f(a_q, mem, f_q.c);
        a_d = ad[DW-1:0];
        f_d.c = ad[DW];
        f_d.v = ad[DW+1];
        f_d.n = ad[DW-1];
        f_d.z = (ad[DW-1:0] == '0);
      end
      cpu_exu_pkg::ACT_AND, cpu_exu_pkg::ACT_ORA, cpu_exu_pkg::ACT_EOR,
      cpu_exu_pkg::ACT_ANC: begin
        if (act_q == cpu_exu_pkg::ACT_ORA) begin
          res = a_q | opd_q;
        end else if (act_q == cpu_exu_pkg::ACT_EOR) begin
          res = a_q ^ opd_q;
        end else begin
          res = a_q & opd_q;
        end
        a_d = res;
        f_d.n = res[DW-1];
        f_d.z = (res == '0);
        if (act_q == cpu_exu_pkg::ACT_ANC) begin
          f_d.c = res[DW-1];
        end
      end
      cpu_exu_pkg::ACT_CMP, cpu_exu_pkg::ACT_CPX, cpu_exu_pkg::ACT_CPY,
      cpu_exu_pkg::ACT_DCP: begin
        if (act_q == cpu_exu_pkg::ACT_CPX) begin
          res = x_q;
        end else if (act_q == cpu_exu_pkg::ACT_CPY) begin
          res = y_q;
        end else begin
          res = a_q;
        end
        mem = (act_q == cpu_exu_pkg::ACT_DCP) ? opd_q - 1'b1 : opd_q;
        // borrow-free subtract: carry out means reg >= operand
        cmp = {1'b0, res} + {1'b0, ~mem} + {{DW{1'b0}}, 1'b1};
        f_d.c = cmp[DW];
        f_d.n = cmp[DW-1];
        f_d.z = (cmp[DW-1:0] == '0);
        if (act_q == cpu_exu_pkg::ACT_DCP) begin
          store_d     = mem;
          store_vld_d = 1'b1;
        end
      end
      cpu_exu_pkg::ACT_BIT: begin
        f_d.z = ((a_q & opd_q) == '0);
        f_d.v = opd_q[DW-2];
        f_d.n = opd_q[DW-1];
      end
      cpu_exu_pkg::ACT_LDA, cpu_exu_pkg::ACT_LDX, cpu_exu_pkg::ACT_LDY: begin
        if (act_q == cpu_exu_pkg::ACT_LDA) a_d = opd_q;
        if (act_q == cpu_exu_pkg::ACT_LDX) x_d = opd_q;
        if (act_q == cpu_exu_pkg::ACT_LDY) y_d = opd_q;
        f_d.n = opd_q[DW-1];
        f_d.z = (opd_q == '0);
      end
      cpu_exu_pkg::ACT_ASL, cpu_exu_pkg::ACT_LSR, cpu_exu_pkg::ACT_ROL,
      cpu_exu_pkg::ACT_ROR: begin
        mem = on_acc_q ? a_q : opd_q;
        sh  = shift_f(cpu_exu_pkg::shift_e'(act_q[1:0]), mem, f_q.c);
        f_d.c = sh[DW];
        f_d.n = sh[DW-1];
        f_d.z = (sh[DW-1:0] == '0);
        if (on_acc_q) begin
          a_d = sh[DW-1:0];
        end else begin
          store_d     = sh[DW-1:0];
          store_vld_d = 1'b1;
        end
      end
      cpu_exu_pkg::ACT_INC, cpu_exu_pkg::ACT_DEC: begin
        res = (act_q == cpu_exu_pkg::ACT_INC) ? opd_q + 1'b1 : opd_q - 1'b1;
        store_d     = res;
        store_vld_d = 1'b1;
        f_d.n = res[DW-1];
        f_d.z = (res == '0);
      end
      cpu_exu_pkg::ACT_INX, cpu_exu_pkg::ACT_DEX, cpu_exu_pkg::ACT_TAX,
      cpu_exu_pkg::ACT_TSX: begin
        priority case (1'b1)
          act_q == cpu_exu_pkg::ACT_INX: res = x_q + 1'b1;
          act_q == cpu_exu_pkg::ACT_DEX: res = x_q - 1'b1;
          act_q == cpu_exu_pkg::ACT_TAX: res = a_q;
          default:                       res = s_q;
        endcase
        x_d = res;
        f_d.n = res[DW-1];
        f_d.z = (res == '0);
      end
      cpu_exu_pkg::ACT_INY, cpu_exu_pkg::ACT_DEY, cpu_exu_pkg::ACT_TAY: begin
        priority case (1'b1)
          act_q == cpu_exu_pkg::ACT_INY: res = y_q + 1'b1;
          act_q == cpu_exu_pkg::ACT_DEY: res = y_q - 1'b1;
          default:                       res = a_q;
        endcase
        y_d = res;
        f_d.n = res[DW-1];
        f_d.z = (res == '0);
      end
      cpu_exu_pkg::ACT_TXA, cpu_exu_pkg::ACT_TYA: begin
        res = (act_q == cpu_exu_pkg::ACT_TXA) ? x_q : y_q;
        a_d = res;
        f_d.n = res[DW-1];
        f_d.z = (res == '0);
      end
      // no flags change on a transfer into the stack pointer
      cpu_exu_pkg::ACT_TXS: s_d = x_q;
      cpu_exu_pkg::ACT_CLC: f_d.c = 1'b0;
      cpu_exu_pkg::ACT_SEC: f_d.c = 1'b1;
      cpu_exu_pkg::ACT_CLD: f_d.d = 1'b0;
      cpu_exu_pkg::ACT_SED: f_d.d = 1'b1;
      cpu_exu_pkg::ACT_CLI: f_d.i = 1'b0;
      cpu_exu_pkg::ACT_SEI: f_d.i = 1'b1;
      cpu_exu_pkg::ACT_CLV: f_d.v = 1'b0;
      cpu_exu_pkg::ACT_STA, cpu_exu_pkg::ACT_STX, cpu_exu_pkg::ACT_STY,
      cpu_exu_pkg::ACT_SAX: begin
        priority case (1'b1)
          act_q == cpu_exu_pkg::ACT_STA: store_d = a_q;
          act_q == cpu_exu_pkg::ACT_STX: store_d = x_q;
          act_q == cpu_exu_pkg::ACT_STY: store_d = y_q;
          default:                       store_d = a_q & x_q;
        endcase
        store_vld_d = 1'b1;
      end
      cpu_exu_pkg::ACT_SLO, cpu_exu_pkg::ACT_RLA, cpu_exu_pkg::ACT_SRE: begin
        // memory step first, then combine its result into A
        priority case (1'b1)
          act_q == cpu_exu_pkg::ACT_SLO: sh = shift_f(cpu_exu_pkg::SH_ASL, opd_q, f_q.c);
          act_q == cpu_exu_pkg::ACT_RLA: sh = shift_f(cpu_exu_pkg::SH_ROL, opd_q, f_q.c);
          default:                       sh = shift_f(cpu_exu_pkg::SH_LSR, opd_q, f_q.c);
        endcase
        store_d     = sh[DW-1:0];
        store_vld_d = 1'b1;
        priority case (1'b1)
          act_q == cpu_exu_pkg::ACT_SLO: res = a_q | sh[DW-1:0];
          act_q == cpu_exu_pkg::ACT_RLA: res = a_q & sh[DW-1:0];
          default:                       res = a_q ^ sh[DW-1:0];
        endcase
        a_d = res;
        f_d.c = sh[DW];
        f_d.n = res[DW-1];
        f_d.z = (res == '0);
      end
      cpu_exu_pkg::ACT_RRA, cpu_exu_pkg::ACT_ISC: begin
        if (act_q == cpu_exu_pkg::ACT_RRA) begin
          sh  = shift_f(cpu_exu_pkg::SH_ROR, opd_q, f_q.c);
          res = sh[DW-1:0];
          mem = res;
          // add uses the carry left by the rotate
          ad  = add_f(a_q, mem, sh[DW]);
        end else begin
          res = opd_q + 1'b1;
          mem = ~res;
          ad  = add_f(a_q, mem, f_q.c);
        end
        store_d     = res;
        store_vld_d = 1'b1;
        a_d = ad[DW-1:0];
        f_d.c = ad[DW];
        f_d.v = ad[DW+1];
        f_d.n = ad[DW-1];
        f_d.z = (ad[DW-1:0] == '0);
      end
      cpu_exu_pkg::ACT_ALR: begin
        sh  = shift_f(cpu_exu_pkg::SH_LSR, a_q & opd_q, f_q.c);
        a_d = sh[DW-1:0];
        f_d.c = sh[DW];
        f_d.n = sh[DW-1];
        f_d.z = (sh[DW-1:0] == '0);
      end
      cpu_exu_pkg::ACT_NOP: begin
      end
      default: begin
        // unused codes act as NOP
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      a_q       <= '0;
      x_q       <= '0;
      y_q       <= '0;
      s_q       <= cpu_exu_pkg::StackReset;
      f_q       <= '0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        a_q       <= a_d;
        x_q       <= x_d;
        y_q       <= y_d;
        s_q       <= s_d;
        f_q       <= f_d;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      act_q    <= in_i.action;
      opd_q    <= in_i.operand;
      on_acc_q <= in_i.on_accumulator;
    end
    if (advance) begin
      store_q     <= store_d;
      store_vld_q <= store_vld_d;
    end
  end

  // register file only moves when the result register loads, so it doubles
  // as the registered result
  assign out_o.valid       = out_vld_q;
  assign out_o.store_value = store_q;
  assign out_o.store_valid = store_vld_q;
  assign out_o.acc_value   = a_q;
  assign out_o.x_value     = x_q;
  assign out_o.y_value     = y_q;
  assign out_o.stack_value = s_q;
  // bit 5 reads as one; break flag is never set by any operation
  assign out_o.status_byte = {f_q.n, f_q.v, 1'b1, 1'b0, f_q.d, f_q.i, f_q.z, f_q.c};

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int unsigned DW = cpu_exu_pkg::DataWidth;

  typedef logic [DW-1:0]                       byte_t;
  typedef logic [cpu_exu_pkg::ActionWidth-1:0] action_t;

  typedef struct packed {
    byte_t store_value;
    logic  store_valid;
    byte_t acc_value;
    byte_t x_value;
    byte_t y_value;
    byte_t stack_value;
    byte_t status_byte;
  } exu_outcome_t;

  localparam int unsigned RandomOps  = 1900;
  localparam int unsigned CycleLimit = 400000;
  localparam action_t     UnusedAct  = 6'd63;

  // Mirrors A, X, Y, S and the flags; queues one expected outcome per beat.
  class exu_outcome_book;
    byte_t               a_reg;
    byte_t               x_reg;
    byte_t               y_reg;
    byte_t               s_reg;
    cpu_exu_pkg::flags_t flg;
    logic                b_flag;
    exu_outcome_t        expected_q[$];
    int unsigned         mismatches;

    function new();
      a_reg      = '0;
      x_reg      = '0;
      y_reg      = '0;
      s_reg      = cpu_exu_pkg::StackReset;
      flg        = '0;
      b_flag     = 1'b0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_nz(byte_t v);
      flg.z = (v == '0);
      flg.n = v[7];
    endfunction

    function void add_with_carry(byte_t m);
      logic [DW:0] sum;
      byte_t       r;
      sum   = {1'b0, a_reg} + {1'b0, m} + {{DW{1'b0}}, flg.c};
      r     = sum[DW-1:0];
      flg.c = sum[DW];
      flg.v = ~(a_reg[7] ^ m[7]) & (a_reg[7] ^ r[7]);
      a_reg = r;
      set_nz(r);
    endfunction

    function void compare_with(byte_t reg_v, byte_t m);
      byte_t diff;
      diff  = reg_v - m;
      flg.c = (reg_v >= m);
      set_nz(diff);
    endfunction

    function byte_t shift_by(cpu_exu_pkg::shift_e kind, byte_t v);
      logic  cin;
      byte_t r;
      cin = flg.c;
      case (kind)
        cpu_exu_pkg::SH_ASL: begin
          flg.c = v[7];
          r     = {v[6:0], 1'b0};
        end
        cpu_exu_pkg::SH_LSR: begin
          flg.c = v[0];
          r     = {1'b0, v[7:1]};
        end
        cpu_exu_pkg::SH_ROL: begin
          flg.c = v[7];
          r     = {v[6:0], cin};
        end
        default: begin
          flg.c = v[0];
          r     = {cin, v[7:1]};
        end
      endcase
      set_nz(r);
      return r;
    endfunction

    function void note_operation(action_t act, byte_t m, logic on_acc);
      exu_outcome_t o;
      byte_t        st;
      logic         sv;
      st = '0;
      sv = 1'b0;
      case (act)
        cpu_exu_pkg::ACT_ADC: add_with_carry(m);
        cpu_exu_pkg::ACT_SBC: add_with_carry(~m);
        cpu_exu_pkg::ACT_AND: begin
          a_reg = a_reg & m;
          set_nz(a_reg);
        end
        cpu_exu_pkg::ACT_ORA: begin
          a_reg = a_reg | m;
          set_nz(a_reg);
        end
        cpu_exu_pkg::ACT_EOR: begin
          a_reg = a_reg ^ m;
          set_nz(a_reg);
        end
        cpu_exu_pkg::ACT_CMP: compare_with(a_reg, m);
        cpu_exu_pkg::ACT_CPX: compare_with(x_reg, m);
        cpu_exu_pkg::ACT_CPY: compare_with(y_reg, m);
        cpu_exu_pkg::ACT_BIT: begin
          flg.z = ((a_reg & m) == '0);
          flg.v = m[6];
          flg.n = m[7];
        end
        cpu_exu_pkg::ACT_LDA: begin
          a_reg = m;
          set_nz(m);
        end
        cpu_exu_pkg::ACT_LDX: begin
          x_reg = m;
          set_nz(m);
        end
        cpu_exu_pkg::ACT_LDY: begin
          y_reg = m;
          set_nz(m);
        end
        cpu_exu_pkg::ACT_ASL, cpu_exu_pkg::ACT_LSR,
        cpu_exu_pkg::ACT_ROL, cpu_exu_pkg::ACT_ROR: begin
          // low two bits of the code select the shift kind
          if (on_acc) begin
            a_reg = shift_by(cpu_exu_pkg::shift_e'(act[1:0]), a_reg);
          end else begin
            st = shift_by(cpu_exu_pkg::shift_e'(act[1:0]), m);
            sv = 1'b1;
          end
        end
        cpu_exu_pkg::ACT_INC: begin
          st = m + 8'd1;
          sv = 1'b1;
          set_nz(st);
        end
        cpu_exu_pkg::ACT_DEC: begin
          st = m - 8'd1;
          sv = 1'b1;
          set_nz(st);
        end
        cpu_exu_pkg::ACT_INX: begin
          x_reg = x_reg + 8'd1;
          set_nz(x_reg);
        end
        cpu_exu_pkg::ACT_INY: begin
          y_reg = y_reg + 8'd1;
          set_nz(y_reg);
        end
        cpu_exu_pkg::ACT_DEX: begin
          x_reg = x_reg - 8'd1;
          set_nz(x_reg);
        end
        cpu_exu_pkg::ACT_DEY: begin
          y_reg = y_reg - 8'd1;
          set_nz(y_reg);
        end
        cpu_exu_pkg::ACT_TAX: begin
          x_reg = a_reg;
          set_nz(x_reg);
        end
        cpu_exu_pkg::ACT_TAY: begin
          y_reg = a_reg;
          set_nz(y_reg);
        end
        cpu_exu_pkg::ACT_TSX: begin
          x_reg = s_reg;
          set_nz(x_reg);
        end
        cpu_exu_pkg::ACT_TXA: begin
          a_reg = x_reg;
          set_nz(a_reg);
        end
        cpu_exu_pkg::ACT_TXS: s_reg = x_reg;
        cpu_exu_pkg::ACT_TYA: begin
          a_reg = y_reg;
          set_nz(a_reg);
        end
        cpu_exu_pkg::ACT_CLC: flg.c = 1'b0;
        cpu_exu_pkg::ACT_SEC: flg.c = 1'b1;
        cpu_exu_pkg::ACT_CLD: flg.d = 1'b0;
        cpu_exu_pkg::ACT_SED: flg.d = 1'b1;
        cpu_exu_pkg::ACT_CLI: flg.i = 1'b0;
        cpu_exu_pkg::ACT_SEI: flg.i = 1'b1;
        cpu_exu_pkg::ACT_CLV: flg.v = 1'b0;
        cpu_exu_pkg::ACT_STA: begin
          st = a_reg;
          sv = 1'b1;
        end
        cpu_exu_pkg::ACT_STX: begin
          st = x_reg;
          sv = 1'b1;
        end
        cpu_exu_pkg::ACT_STY: begin
          st = y_reg;
          sv = 1'b1;
        end
        // combined ops: memory step first, accumulator step on its result
        cpu_exu_pkg::ACT_SLO: begin
          st    = shift_by(cpu_exu_pkg::SH_ASL, m);
          sv    = 1'b1;
          a_reg = a_reg | st;
          set_nz(a_reg);
        end
        cpu_exu_pkg::ACT_RLA: begin
          st    = shift_by(cpu_exu_pkg::SH_ROL, m);
          sv    = 1'b1;
          a_reg = a_reg & st;
          set_nz(a_reg);
        end
        cpu_exu_pkg::ACT_SRE: begin
          st    = shift_by(cpu_exu_pkg::SH_LSR, m);
          sv    = 1'b1;
          a_reg = a_reg ^ st;
          set_nz(a_reg);
        end
        cpu_exu_pkg::ACT_RRA: begin
          st = shift_by(cpu_exu_pkg::SH_ROR, m);
          sv = 1'b1;
          add_with_carry(st);
        end
        cpu_exu_pkg::ACT_DCP: begin
          st = m - 8'd1;
          sv = 1'b1;
          compare_with(a_reg, st);
        end
        cpu_exu_pkg::ACT_ISC: begin
          st = m + 8'd1;
          sv = 1'b1;
          add_with_carry(~st);
        end
        cpu_exu_pkg::ACT_ALR: a_reg = shift_by(cpu_exu_pkg::SH_LSR, a_reg & m);
        cpu_exu_pkg::ACT_ANC: begin
          a_reg = a_reg & m;
          set_nz(a_reg);
          flg.c = a_reg[7];
        end
        cpu_exu_pkg::ACT_SAX: begin
          st = a_reg & x_reg;
          sv = 1'b1;
        end
        default: ;
      endcase
      o.store_value = sv ? st : '0;
      o.store_valid = sv;
      o.acc_value   = a_reg;
      o.x_value     = x_reg;
      o.y_value     = y_reg;
      o.stack_value = s_reg;
      o.status_byte = {flg.n, flg.v, 1'b1, b_flag, flg.d, flg.i, flg.z, flg.c};
      expected_q.push_back(o);
    endfunction

    function void check_field(string name, byte_t want, byte_t seen);
      if (seen !== want) begin
        $error("%s expected %02h got %02h", name, want, seen);
        mismatches++;
      end
    endfunction

    function void check_outcome(exu_outcome_t got);
      exu_outcome_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with no outstanding operation");
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      check_field("store_value", want.store_value, got.store_value);
      check_field("store_valid", {7'd0, want.store_valid}, {7'd0, got.store_valid});
      check_field("acc_value", want.acc_value, got.acc_value);
      check_field("x_value", want.x_value, got.x_value);
      check_field("y_value", want.y_value, got.y_value);
      check_field("stack_value", want.stack_value, got.stack_value);
      check_field("status_byte", want.status_byte, got.status_byte);
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        steady      = 1'b0;
  int unsigned cycle_count = 0;

  exu_outcome_book book = new();

  cpu_exu_in_if  in_if ();
  cpu_exu_out_if out_if ();

  cpu6502_execute_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_if.ready <= steady || ($urandom_range(99) >= 27);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        book.note_operation(in_if.action, in_if.operand, in_if.on_accumulator);
      end
      if (out_if.valid && out_if.ready) begin
        book.check_outcome(exu_outcome_t'{out_if.store_value, out_if.store_valid,
                                          out_if.acc_value, out_if.x_value, out_if.y_value,
                                          out_if.stack_value, out_if.status_byte});
      end
    end
  end

  task automatic send_op(input action_t act, input byte_t opnd, input logic on_acc);
    while (!steady && $urandom_range(99) < 27) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.action         <= act;
    in_if.operand        <= opnd;
    in_if.on_accumulator <= on_acc;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
  endtask

  // hold off new beats until every outstanding result is back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (book.pending() != 0) @(posedge clk_i);
  endtask

  function automatic byte_t pick_operand();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      4:       return 8'h01;
      default: return byte_t'($urandom_range(255));
    endcase
  endfunction

  initial begin
    action_t act;
    in_if.valid          <= 1'b0;
    in_if.action         <= cpu_exu_pkg::ACT_NOP;
    in_if.operand        <= '0;
    in_if.on_accumulator <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_op(cpu_exu_pkg::ACT_LDA, 8'h00, 1'b0);
    send_op(cpu_exu_pkg::ACT_LDA, 8'h7F, 1'b0);
    send_op(cpu_exu_pkg::ACT_CLC, 8'hFF, 1'b1);
    send_op(cpu_exu_pkg::ACT_ADC, 8'h01, 1'b0);   // signed overflow into N
    send_op(cpu_exu_pkg::ACT_ADC, 8'hFF, 1'b0);   // carry out
    send_op(cpu_exu_pkg::ACT_SEC, 8'h00, 1'b0);
    send_op(cpu_exu_pkg::ACT_SBC, 8'h80, 1'b0);
    send_op(cpu_exu_pkg::ACT_CMP, 8'h80, 1'b0);
    send_op(cpu_exu_pkg::ACT_CPX, 8'h00, 1'b0);
    send_op(cpu_exu_pkg::ACT_CPY, 8'hFF, 1'b0);
    send_op(cpu_exu_pkg::ACT_BIT, 8'hC0, 1'b0);
    send_op(cpu_exu_pkg::ACT_BIT, 8'h00, 1'b1);
    send_op(cpu_exu_pkg::ACT_ASL, 8'h00, 1'b1);
    send_op(cpu_exu_pkg::ACT_LSR, 8'h01, 1'b0);
    send_op(cpu_exu_pkg::ACT_ROR, 8'h01, 1'b0);
    send_op(cpu_exu_pkg::ACT_ROL, 8'hFF, 1'b1);
    send_op(cpu_exu_pkg::ACT_INC, 8'hFF, 1'b1);   // accumulator bit ignored
    send_op(cpu_exu_pkg::ACT_DEC, 8'h00, 1'b0);
    send_op(cpu_exu_pkg::ACT_LDX, 8'h80, 1'b0);
    send_op(cpu_exu_pkg::ACT_TXS, 8'h00, 1'b0);   // flags untouched
    send_op(cpu_exu_pkg::ACT_SED, 8'h00, 1'b0);
    send_op(cpu_exu_pkg::ACT_ADC, 8'h99, 1'b0);   // still binary with D set
    send_op(cpu_exu_pkg::ACT_RRA, 8'h01, 1'b0);   // rotate carry feeds the add
    send_op(cpu_exu_pkg::ACT_ISC, 8'hFF, 1'b0);
    send_op(UnusedAct, 8'h5A, 1'b1);              // unused code acts as NOP

    for (int unsigned i = 0; i < RandomOps; i++) begin
      if (i == 700) steady <= 1'b1;
      if (i == 1100) steady <= 1'b0;
      if (i == 400 || i == 1500) wait_drained();
      if ($urandom_range(15) == 0) begin
        act = action_t'($urandom_range(63, 48));
      end else begin
        act = action_t'($urandom_range(47));
      end
      send_op(act, pick_operand(), 1'($urandom_range(1)));
    end

    wait_drained();
    repeat (6) @(posedge clk_i);
    if (book.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
